/* rtl/mavg_pkg.sv */
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants of the moving-average gain control block.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

  // Width of one channel count, one window entry and the average.
  localparam int DATA_W = 16;
  // Width of the gain index.
  localparam int GAIN_W = 2;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 2'd3;
  localparam logic [GAIN_W-1:0] GAIN_MIN = 2'd0;

  // Default number of entries in the averaging window.
  localparam int WINDOW_DEPTH_DEF = 8;

  // Register reset values.
  localparam logic [DATA_W-1:0] LOW_THR_RST  = 16'd1000;
  localparam logic [DATA_W-1:0] HIGH_THR_RST = 16'd8000;
  localparam logic [DATA_W-1:0] SAT_LIM_RST  = 16'd9500;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR  = 2'd0,
    CFG_HIGH_THR = 2'd1,
    CFG_SAT_LIM  = 2'd2
  } cfg_idx_e;

  // Sum of three channels and the reciprocal of three used for the mean.
  // floor(x/3) = (x * ceil(2^19/3)) >> 19 for every x below 2^18.
  localparam int SUM3_W   = DATA_W + 2;
  localparam int DIV3_SH  = 19;
  localparam logic [SUM3_W-1:0] DIV3_MUL = 18'd174763;

  // Result buffer.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PW    = 3;
  localparam int OUT_CW    = 4;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_step;
    logic              gain_changed;
    logic [DATA_W-1:0] average_level;
  } result_t;

endpackage

`default_nettype wire

/* rtl/mavg_ram.sv */
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/moving_average_gain_control_top.sv */
// ----------------------------------------------------------------------------
// moving_average_gain_control_top
// Moving-average automatic gain control over red, green and blue samples.
// ----------------------------------------------------------------------------
// A result word passes the pipeline stage registers and is written to the
// result buffer before it can be taken on the result channel.
// Throughput: one word per cycle; the input stalls only when eight words are
// outstanding, which is set by the depth of the result buffer.
// Reset: the window reads as all zeros at once (per-entry valid bits), the
// running total is zero, the gain is 3 and the registers take defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_gain_control_top #(
  parameter int WINDOW_DEPTH = mavg_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Sample channel.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [mavg_pkg::DATA_W-1:0]    red_i,
  input  wire logic [mavg_pkg::DATA_W-1:0]    green_i,
  input  wire logic [mavg_pkg::DATA_W-1:0]    blue_i,
  // Result channel.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [mavg_pkg::GAIN_W-1:0]    gain_step_o,
  output logic                                gain_changed_o,
  output logic      [mavg_pkg::DATA_W-1:0]    average_level_o,
  // Configuration write channel.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mavg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mavg_pkg::DATA_W-1:0]    cfg_data_i
);

  import mavg_pkg::*;

  // Window addressing and running-total width. The total of WINDOW_DEPTH
  // entries of 16 bits always fits in DATA_W + ceil(log2(depth)) bits.
  localparam int SW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LG  = $clog2(WINDOW_DEPTH);
  localparam int TW  = DATA_W + LG;
  // The average is total / depth, done as a multiply by ceil(2^SH / depth)
  // and a shift. The rounding error stays below one part in depth, so the
  // truncated quotient is exact for every total below 2^TW.
  localparam int SH  = TW + LG;
  localparam longint unsigned DIVD_L =
      ((64'd1 << SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam int MW  = TW + 1;
  localparam int PW  = TW + MW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW_DEPTH - 1);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes to an index past the list are dropped.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] low_thr_q, high_thr_q, sat_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
      sat_lim_q  <= SAT_LIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_THR:  low_thr_q  <= cfg_data_i;
        CFG_HIGH_THR: high_thr_q <= cfg_data_i;
        CFG_SAT_LIM:  sat_lim_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The pipeline itself never stalls; instead the number of
  // words taken but not yet delivered is held at or below the depth of the
  // result buffer, so every word in flight always has a buffer slot waiting.
  // --------------------------------------------------------------------------
  logic              in_acc, out_acc;
  logic [OUT_CW-1:0] outst_q;

  assign in_ready_o = (outst_q < OUT_CW'(OUT_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (in_acc && !out_acc) begin
      outst_q <= outst_q + OUT_CW'(1);
    end else if (!in_acc && out_acc) begin
      outst_q <= outst_q - OUT_CW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0 (accept): the slot about to be overwritten is read from the
  // window RAM, the channel sum is formed and saturation is checked.
  // --------------------------------------------------------------------------
  logic [SW-1:0]           slot_q;
  logic [WINDOW_DEPTH-1:0] ent_vld_q;

  // Stage 1 registers.
  logic              v1_q;
  logic [SUM3_W-1:0] sum1_q;
  logic              sat1_q;
  logic [SW-1:0]     slot1_q;
  logic              ent_vld1_q;
  logic              byp1_q;
  logic [DATA_W-1:0] byp_data1_q;

  // Stage 1 combinational mean, which is also the word written to the RAM.
  logic [2*SUM3_W-1:0] prod3;
  logic [DATA_W-1:0]   mean1;
  logic [DATA_W-1:0]   rd_data;
  logic [DATA_W-1:0]   old1;
  logic                byp;

  assign prod3 = (2*SUM3_W)'(sum1_q) * (2*SUM3_W)'(DIV3_MUL);
  assign mean1 = prod3[DIV3_SH +: DATA_W];

  // Only a window of one entry lets the next word read the slot that stage 1
  // is writing in the same cycle; the new mean is forwarded around the RAM.
  assign byp = v1_q && (slot1_q == slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      ent_vld_q <= '0;
      v1_q      <= 1'b0;
    end else begin
      v1_q <= in_acc;
      if (in_acc) begin
        slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + SW'(1);
      end
      if (v1_q) begin
        ent_vld_q[slot1_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum1_q      <= SUM3_W'(red_i) + SUM3_W'(green_i) + SUM3_W'(blue_i);
      sat1_q      <= (red_i > sat_lim_q) || (green_i > sat_lim_q) ||
                     (blue_i > sat_lim_q);
      slot1_q     <= slot_q;
      ent_vld1_q  <= ent_vld_q[slot_q];
      byp1_q      <= byp;
      byp_data1_q <= mean1;
    end
  end

  mavg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_DEPTH),
    .AW    (SW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (slot1_q),
    .wdata_i (mean1),
    .re_i    (in_acc),
    .raddr_i (slot_q),
    .rdata_o (rd_data)
  );

  // An entry never written since reset counts as zero.
  always_comb begin
    if (byp1_q) begin
      old1 = byp_data1_q;
    end else if (ent_vld1_q) begin
      old1 = rd_data;
    end else begin
      old1 = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the running total drops the old entry and adds the new mean.
  // --------------------------------------------------------------------------
  logic              v2_q;
  logic [DATA_W-1:0] mean2_q, old2_q;
  logic              sat2_q;
  logic [TW-1:0]     total_q, total_d;

  assign total_d = total_q - TW'(old2_q) + TW'(mean2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      total_q <= '0;
    end else begin
      v2_q <= v1_q;
      if (v2_q) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      mean2_q <= mean1;
      old2_q  <= old1;
      sat2_q  <= sat1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: the average is the updated total divided by the window depth.
  // --------------------------------------------------------------------------
  logic          v3_q;
  logic          sat3_q;
  logic [PW-1:0] prodd;

  assign prodd = PW'(total_q) * PW'(MW'(DIVD_L));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      sat3_q <= sat2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: gain decision. A raise has priority over a decrease, and neither
  // happens at the end of the gain range.
  // --------------------------------------------------------------------------
  logic              v4_q;
  logic              sat4_q;
  logic [DATA_W-1:0] avg4_q;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic              raise, lower;
  result_t           res4;

  assign raise = (avg4_q < low_thr_q) && (gain_q != GAIN_MAX);
  assign lower = !raise && ((avg4_q > high_thr_q) || sat4_q) && (gain_q != GAIN_MIN);

  always_comb begin
    gain_d = gain_q;
    if (raise) begin
      gain_d = gain_q + GAIN_W'(1);
    end else if (lower) begin
      gain_d = gain_q - GAIN_W'(1);
    end
    res4.gain_step     = gain_d;
    res4.gain_changed  = raise || lower;
    res4.average_level = avg4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q   <= 1'b0;
      gain_q <= GAIN_MAX;
    end else begin
      v4_q <= v3_q;
      if (v4_q) begin
        gain_q <= gain_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      avg4_q <= prodd[SH +: DATA_W];
      sat4_q <= sat3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer. The outstanding-word limit guarantees it never overflows.
  // --------------------------------------------------------------------------
  result_t           res_q [OUT_DEPTH];
  logic [OUT_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CW-1:0] fill_q;
  result_t           res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (v4_q) begin
        wr_ptr_q <= wr_ptr_q + OUT_PW'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + OUT_PW'(1);
      end
      if (v4_q && !out_acc) begin
        fill_q <= fill_q + OUT_CW'(1);
      end else if (!v4_q && out_acc) begin
        fill_q <= fill_q - OUT_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      res_q[wr_ptr_q] <= res4;
    end
  end

  assign res_out         = res_q[rd_ptr_q];
  assign out_valid_o     = (fill_q != '0);
  assign gain_step_o     = res_out.gain_step;
  assign gain_changed_o  = res_out.gain_changed;
  assign average_level_o = res_out.average_level;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // Words taken but not delivered never exceed the buffer depth.
  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= OUT_CW'(OUT_DEPTH))
    else $error("outstanding word count exceeds result buffer depth");

  // Buffered results are a subset of the outstanding words.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= outst_q)
    else $error("result buffer holds more words than are outstanding");

  // The gain only moves when the decision stage reports a change.
  a_gain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v4_q && res4.gain_changed) |=> $stable(gain_q))
    else $error("gain moved without a reported change");

  // A reported change really moves the gain.
  a_gain_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && res4.gain_changed) |=> (gain_q != $past(gain_q)))
    else $error("reported gain change did not move the gain");

endmodule

`default_nettype wire
